[rtl/brpc_pkg.sv]
`default_nettype none
package brpc_pkg;

    localparam int unsigned AddrWidth = 5;
    localparam int unsigned RegIdxWidth = 3;

    // register indexes
    localparam logic [RegIdxWidth-1:0] REG_TRIP_TEMP    = 3'd0;
    localparam logic [RegIdxWidth-1:0] REG_RELEASE_TEMP = 3'd1;
    localparam logic [RegIdxWidth-1:0] REG_FAN_TEMP     = 3'd2;
    localparam logic [RegIdxWidth-1:0] REG_CHG_BEGIN    = 3'd3;
    localparam logic [RegIdxWidth-1:0] REG_CHG_END      = 3'd4;
    localparam logic [RegIdxWidth-1:0] REG_INFLOW_LIMIT = 3'd5;
    localparam logic [RegIdxWidth-1:0] REG_BLANK_WINDOW = 3'd6;

    // register reset values
    localparam logic signed [11:0] RST_TRIP_TEMP    = 12'sd600;
    localparam logic signed [11:0] RST_RELEASE_TEMP = 12'sd350;
    localparam logic signed [11:0] RST_FAN_TEMP     = 12'sd400;
    localparam logic [15:0]        RST_CHG_BEGIN    = 16'd11000;
    localparam logic [15:0]        RST_CHG_END      = 16'd12600;
    localparam logic signed [15:0] RST_INFLOW_LIMIT = -16'sd200;
    localparam logic [15:0]        RST_BLANK_WINDOW = 16'd500;

    // alert mask bit positions
    localparam int unsigned ALERT_TRIP     = 0;
    localparam int unsigned ALERT_CLEAR    = 1;
    localparam int unsigned ALERT_READY    = 2;
    localparam int unsigned ALERT_COMPLETE = 3;
    localparam int unsigned ALERT_STOPPED  = 4;
    localparam int unsigned ALERT_IN_START = 5;
    localparam int unsigned ALERT_IN_STOP  = 6;
    localparam int unsigned AlertWidth     = 7;

    localparam logic CAUSE_FAULT = 1'b0;
    localparam logic CAUSE_TEMP  = 1'b1;

    localparam logic [15:0] CycleMax = 16'hFFFF;

    typedef struct packed {
        logic signed [11:0] trip_temp_dc;
        logic signed [11:0] release_temp_dc;
        logic signed [11:0] fan_start_temp_dc;
        logic [15:0]        charge_begin_mv;
        logic [15:0]        charge_end_mv;
        logic signed [15:0] inflow_limit_ma;
        logic [15:0]        blank_window_ms;
    } t_cfg;

    typedef struct packed {
        logic signed [11:0] temp_dc;
        logic [15:0]        pack_mv;
        logic signed [15:0] current_ma;
        logic               fault_flag;
        logic [31:0]        now_ms;
    } t_in_word;

    typedef struct packed {
        logic                  charge_relay;
        logic                  motor_relay;
        logic                  fan_relay;
        logic                  trip_active;
        logic                  inrush_blanking;
        logic [AlertWidth-1:0] alert_mask;
        logic                  stop_cause;
        logic [15:0]           cycles_done;
    } t_res_word;

endpackage
`default_nettype wire

[rtl/brpc_if.sv]
`default_nettype none
interface brpc_in_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] temp_dc;
    logic [15:0]        pack_mv;
    logic signed [15:0] current_ma;
    logic               fault_flag;
    logic [31:0]        now_ms;

    modport source (output valid, temp_dc, pack_mv, current_ma, fault_flag, now_ms,
                    input ready);
    modport sink (input valid, temp_dc, pack_mv, current_ma, fault_flag, now_ms,
                  output ready);
endinterface

interface brpc_out_if;
    logic        valid;
    logic        ready;
    logic        charge_relay;
    logic        motor_relay;
    logic        fan_relay;
    logic        trip_active;
    logic        inrush_blanking;
    logic [6:0]  alert_mask;
    logic        stop_cause;
    logic [15:0] cycles_done;

    modport source (output valid, charge_relay, motor_relay, fan_relay, trip_active,
                    inrush_blanking, alert_mask, stop_cause, cycles_done,
                    input ready);
    modport sink (input valid, charge_relay, motor_relay, fan_relay, trip_active,
                  inrush_blanking, alert_mask, stop_cause, cycles_done,
                  output ready);
endinterface
`default_nettype wire

[rtl/brpc_cfg.sv]
`default_nettype none
module brpc_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [brpc_pkg::AddrWidth-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output brpc_pkg::t_cfg                      o_cfg
);

    brpc_pkg::t_cfg r_cfg;
    logic [brpc_pkg::RegIdxWidth-1:0] w_idx;
    logic w_wr;

    assign w_idx  = paddr[brpc_pkg::AddrWidth-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trip_temp_dc      <= brpc_pkg::RST_TRIP_TEMP;
            r_cfg.release_temp_dc   <= brpc_pkg::RST_RELEASE_TEMP;
            r_cfg.fan_start_temp_dc <= brpc_pkg::RST_FAN_TEMP;
            r_cfg.charge_begin_mv   <= brpc_pkg::RST_CHG_BEGIN;
            r_cfg.charge_end_mv     <= brpc_pkg::RST_CHG_END;
            r_cfg.inflow_limit_ma   <= brpc_pkg::RST_INFLOW_LIMIT;
            r_cfg.blank_window_ms   <= brpc_pkg::RST_BLANK_WINDOW;
        end else if (w_wr) begin
            case (w_idx)
                brpc_pkg::REG_TRIP_TEMP:    r_cfg.trip_temp_dc      <= $signed(pwdata[11:0]);
                brpc_pkg::REG_RELEASE_TEMP: r_cfg.release_temp_dc   <= $signed(pwdata[11:0]);
                brpc_pkg::REG_FAN_TEMP:     r_cfg.fan_start_temp_dc <= $signed(pwdata[11:0]);
                brpc_pkg::REG_CHG_BEGIN:    r_cfg.charge_begin_mv   <= pwdata[15:0];
                brpc_pkg::REG_CHG_END:      r_cfg.charge_end_mv     <= pwdata[15:0];
                brpc_pkg::REG_INFLOW_LIMIT: r_cfg.inflow_limit_ma   <= $signed(pwdata[15:0]);
                brpc_pkg::REG_BLANK_WINDOW: r_cfg.blank_window_ms   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            brpc_pkg::REG_TRIP_TEMP:    prdata = {20'd0, r_cfg.trip_temp_dc};
            brpc_pkg::REG_RELEASE_TEMP: prdata = {20'd0, r_cfg.release_temp_dc};
            brpc_pkg::REG_FAN_TEMP:     prdata = {20'd0, r_cfg.fan_start_temp_dc};
            brpc_pkg::REG_CHG_BEGIN:    prdata = {16'd0, r_cfg.charge_begin_mv};
            brpc_pkg::REG_CHG_END:      prdata = {16'd0, r_cfg.charge_end_mv};
            brpc_pkg::REG_INFLOW_LIMIT: prdata = {16'd0, r_cfg.inflow_limit_ma};
            brpc_pkg::REG_BLANK_WINDOW: prdata = {16'd0, r_cfg.blank_window_ms};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/brpc_core.sv]
`default_nettype none
module brpc_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire brpc_pkg::t_cfg i_cfg,
    brpc_in_if.sink             i_in,
    brpc_out_if.source          o_res
);

    // input stage
    logic               r_in_valid;
    brpc_pkg::t_in_word r_in;
    // result stage
    logic                r_out_valid;
    brpc_pkg::t_res_word r_out;
    // controller state
    logic        r_tripped;
    logic        r_fan_on;
    logic        r_charging;
    logic        r_allow_prev;
    logic [31:0] r_stamp;
    logic        r_stamp_valid;
    logic        r_inflow_seen;
    logic [15:0] r_cycles;

    logic        n_tripped;
    logic        n_fan_on;
    logic        n_charging;
    logic [31:0] n_stamp;
    logic        n_stamp_valid;
    logic        n_inflow_seen;
    logic [15:0] n_cycles;
    brpc_pkg::t_res_word n_res;

    logic w_adv;
    logic w_take;

    assign w_adv   = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_take  = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.temp_dc    <= i_in.temp_dc;
            r_in.pack_mv    <= i_in.pack_mv;
            r_in.current_ma <= i_in.current_ma;
            r_in.fault_flag <= i_in.fault_flag;
            r_in.now_ms     <= i_in.now_ms;
        end
    end

    // one tick of the controller, in fixed order
    always_comb begin
        logic        trip_set;
        logic        trip_a;
        logic        chg_a;
        logic        clr;
        logic        stop;
        logic        ready_ev;
        logic        chg_r;
        logic        done_ev;
        logic        inflow;
        logic        allow;
        logic [31:0] elapsed;
        logic        fault;

        fault    = r_in.fault_flag;
        trip_set = !r_tripped && ($signed(r_in.temp_dc) >= $signed(i_cfg.trip_temp_dc));
        trip_a   = r_tripped || trip_set;
        chg_a    = r_charging && !trip_set;
        clr      = trip_a && ($signed(r_in.temp_dc) < $signed(i_cfg.release_temp_dc));
        n_tripped = trip_a && !clr;

        n_fan_on = fault || n_tripped
                || ($signed(r_in.temp_dc) >= $signed(i_cfg.fan_start_temp_dc))
                || (r_fan_on && ($signed(r_in.temp_dc) >= $signed(i_cfg.release_temp_dc)));

        stop     = 1'b0;
        ready_ev = 1'b0;
        done_ev  = 1'b0;
        chg_r    = chg_a;
        n_cycles = r_cycles;
        if (fault || n_tripped) begin
            stop       = chg_a;
            n_charging = 1'b0;
        end else begin
            ready_ev   = !chg_a && (r_in.pack_mv <= i_cfg.charge_begin_mv);
            chg_r      = chg_a || ready_ev;
            done_ev    = chg_r && (r_in.pack_mv >= i_cfg.charge_end_mv);
            n_charging = chg_r && !done_ev;
            if (done_ev && (r_cycles != brpc_pkg::CycleMax)) begin
                n_cycles = r_cycles + 16'd1;
            end
        end

        inflow = $signed(r_in.current_ma) < $signed(i_cfg.inflow_limit_ma);
        allow  = !fault && !n_tripped && !inflow;

        n_stamp       = r_stamp;
        n_stamp_valid = r_stamp_valid;
        if (allow != r_allow_prev) begin
            if (allow) begin
                n_stamp       = r_in.now_ms;
                n_stamp_valid = 1'b1;
            end else begin
                n_stamp_valid = 1'b0;
            end
        end
        elapsed = r_in.now_ms - n_stamp;

        n_inflow_seen = inflow;

        n_res.charge_relay    = n_charging;
        n_res.motor_relay     = allow;
        n_res.fan_relay       = n_fan_on;
        n_res.trip_active     = n_tripped;
        n_res.inrush_blanking = n_stamp_valid && (elapsed < {16'd0, i_cfg.blank_window_ms});
        n_res.alert_mask = '0;
        n_res.alert_mask[brpc_pkg::ALERT_TRIP]     = trip_set;
        n_res.alert_mask[brpc_pkg::ALERT_CLEAR]    = clr;
        n_res.alert_mask[brpc_pkg::ALERT_READY]    = ready_ev;
        n_res.alert_mask[brpc_pkg::ALERT_COMPLETE] = done_ev;
        n_res.alert_mask[brpc_pkg::ALERT_STOPPED]  = stop;
        n_res.alert_mask[brpc_pkg::ALERT_IN_START] = inflow && !r_inflow_seen;
        n_res.alert_mask[brpc_pkg::ALERT_IN_STOP]  = !inflow && r_inflow_seen;
        n_res.stop_cause  = (stop && !fault) ? brpc_pkg::CAUSE_TEMP : brpc_pkg::CAUSE_FAULT;
        n_res.cycles_done = n_cycles;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tripped     <= 1'b0;
            r_fan_on      <= 1'b0;
            r_charging    <= 1'b0;
            r_allow_prev  <= 1'b1;
            r_stamp       <= 32'd0;
            r_stamp_valid <= 1'b0;
            r_inflow_seen <= 1'b0;
            r_cycles      <= 16'd0;
        end else if (w_adv) begin
            r_tripped     <= n_tripped;
            r_fan_on      <= n_fan_on;
            r_charging    <= n_charging;
            r_allow_prev  <= n_res.motor_relay;
            r_stamp       <= n_stamp;
            r_stamp_valid <= n_stamp_valid;
            r_inflow_seen <= n_inflow_seen;
            r_cycles      <= n_cycles;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.charge_relay    = r_out.charge_relay;
    assign o_res.motor_relay     = r_out.motor_relay;
    assign o_res.fan_relay       = r_out.fan_relay;
    assign o_res.trip_active     = r_out.trip_active;
    assign o_res.inrush_blanking = r_out.inrush_blanking;
    assign o_res.alert_mask      = r_out.alert_mask;
    assign o_res.stop_cause      = r_out.stop_cause;
    assign o_res.cycles_done     = r_out.cycles_done;

    a_trip_opens_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.charge_relay && r_out.trip_active))
        else $error("charge relay closed while tripped");

    a_blank_needs_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.inrush_blanking |-> r_out.motor_relay)
        else $error("blanking with motor relay open");

    a_state_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_tripped == r_out.trip_active) && (r_charging == r_out.charge_relay)
                  && (r_cycles == r_out.cycles_done))
        else $error("state and result word disagree");

    a_cycles_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_cycles >= $past(r_cycles))
        else $error("cycle counter went backward");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result word lost");

endmodule
`default_nettype wire

[rtl/battery_relay_protection_controller_top.sv]
`default_nettype none
// Channel   Dir   Handshake        Word
// i_in      in    valid / ready    temp_dc, pack_mv, current_ma, fault_flag, now_ms
// o_res     out   valid / ready    relays, trip, blanking, alert_mask, stop_cause, cycles_done
// apb       in    psel / penable   7 registers at byte address 4*index, writes only when idle
//                                  (a rule for the user; the block leaves it unenforced)
// One word per cycle sustained while o_res is not stalled; an accepted word goes through the
// input register, then the single evaluation pass into the result register.
// Synchronous active-low reset clears controller state, valid flags and config registers to their defaults.
// A stalled result holds while one more word waits in the input register; beyond that
// i_in.ready drops.
module battery_relay_protection_controller_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    brpc_in_if.sink                             i_in,
    brpc_out_if.source                          o_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [brpc_pkg::AddrWidth-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    brpc_pkg::t_cfg w_cfg;

    brpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    brpc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

[tb/sv/tb_battery_relay_protection_controller_top.sv]
`timescale 1ns / 1ps

// Tracks the controller's thresholds and latched state and predicts one result
// word per accepted input word.
class relay_tick_model;
    logic signed [11:0] trip_lvl;
    logic signed [11:0] release_lvl;
    logic signed [11:0] fan_lvl;
    logic [15:0]        chg_on_mv;
    logic [15:0]        chg_off_mv;
    logic signed [15:0] inflow_lvl;
    logic [15:0]        window_ms;

    bit          tripped;
    bit          fan_on;
    bit          charging_on;
    bit          allow_prev;
    bit          stamp_ok;
    bit          inflow_seen;
    logic [31:0] start_stamp;
    logic [15:0] cycle_count;

    brpc_pkg::t_res_word pending_results[$];
    int unsigned err_count;
    int unsigned checked;

    function new();
        trip_lvl    = brpc_pkg::RST_TRIP_TEMP;
        release_lvl = brpc_pkg::RST_RELEASE_TEMP;
        fan_lvl     = brpc_pkg::RST_FAN_TEMP;
        chg_on_mv   = brpc_pkg::RST_CHG_BEGIN;
        chg_off_mv  = brpc_pkg::RST_CHG_END;
        inflow_lvl  = brpc_pkg::RST_INFLOW_LIMIT;
        window_ms   = brpc_pkg::RST_BLANK_WINDOW;
        tripped     = 1'b0;
        fan_on      = 1'b0;
        charging_on = 1'b0;
        allow_prev  = 1'b1;
        stamp_ok    = 1'b0;
        inflow_seen = 1'b0;
        start_stamp = '0;
        cycle_count = '0;
        err_count   = 0;
        checked     = 0;
    endfunction

    function void write_reg(logic [brpc_pkg::RegIdxWidth-1:0] idx, logic [31:0] value);
        case (idx)
            brpc_pkg::REG_TRIP_TEMP:    trip_lvl    = value[11:0];
            brpc_pkg::REG_RELEASE_TEMP: release_lvl = value[11:0];
            brpc_pkg::REG_FAN_TEMP:     fan_lvl     = value[11:0];
            brpc_pkg::REG_CHG_BEGIN:    chg_on_mv   = value[15:0];
            brpc_pkg::REG_CHG_END:      chg_off_mv  = value[15:0];
            brpc_pkg::REG_INFLOW_LIMIT: inflow_lvl  = value[15:0];
            brpc_pkg::REG_BLANK_WINDOW: window_ms   = value[15:0];
            default: ;
        endcase
    endfunction

    function void note_tick(brpc_pkg::t_in_word w);
        logic signed [11:0]  temp;
        logic signed [15:0]  cur;
        logic [31:0]         elapsed;
        bit                  fault;
        bit                  inflow;
        bit                  allow;
        brpc_pkg::t_res_word r;
        temp   = w.temp_dc;
        cur    = w.current_ma;
        fault  = w.fault_flag;
        r      = '0;
        inflow = (cur < inflow_lvl);

        if (!tripped && temp >= trip_lvl) begin
            tripped = 1'b1;
            charging_on = 1'b0;
            r.alert_mask[brpc_pkg::ALERT_TRIP] = 1'b1;
        end
        if (tripped && temp < release_lvl) begin
            tripped = 1'b0;
            r.alert_mask[brpc_pkg::ALERT_CLEAR] = 1'b1;
        end

        fan_on = fault || tripped || temp >= fan_lvl || (fan_on && temp >= release_lvl);

        if (fault || tripped) begin
            if (charging_on) begin
                charging_on = 1'b0;
                r.alert_mask[brpc_pkg::ALERT_STOPPED] = 1'b1;
                r.stop_cause = fault ? brpc_pkg::CAUSE_FAULT : brpc_pkg::CAUSE_TEMP;
            end
        end else begin
            if (!charging_on && w.pack_mv <= chg_on_mv) begin
                charging_on = 1'b1;
                r.alert_mask[brpc_pkg::ALERT_READY] = 1'b1;
            end
            if (charging_on && w.pack_mv >= chg_off_mv) begin
                charging_on = 1'b0;
                if (cycle_count < brpc_pkg::CycleMax) cycle_count++;
                r.alert_mask[brpc_pkg::ALERT_COMPLETE] = 1'b1;
            end
        end

        allow = !fault && !tripped && !inflow;
        if (allow != allow_prev) begin
            if (allow) begin
                start_stamp = w.now_ms;
                stamp_ok = 1'b1;
            end else begin
                stamp_ok = 1'b0;
            end
            allow_prev = allow;
        end
        // elapsed time wraps with the timestamp
        elapsed = w.now_ms - start_stamp;

        if (inflow && !inflow_seen) begin
            inflow_seen = 1'b1;
            r.alert_mask[brpc_pkg::ALERT_IN_START] = 1'b1;
        end
        if (!inflow && inflow_seen) begin
            inflow_seen = 1'b0;
            r.alert_mask[brpc_pkg::ALERT_IN_STOP] = 1'b1;
        end

        r.charge_relay    = charging_on;
        r.motor_relay     = allow;
        r.fan_relay       = fan_on;
        r.trip_active     = tripped;
        r.inrush_blanking = stamp_ok && (elapsed < {16'd0, window_ms});
        r.cycles_done     = cycle_count;
        pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, longint unsigned want, longint unsigned got);
        err_count++;
        if (err_count <= 100)
            $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                     $time, checked, what, want, got);
    endtask

    task check_result(brpc_pkg::t_res_word got);
        brpc_pkg::t_res_word want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", 0, got);
        end else begin
            want = pending_results.pop_front();
            if (got.charge_relay !== want.charge_relay)
                report_mismatch("charge_relay", want.charge_relay, got.charge_relay);
            if (got.motor_relay !== want.motor_relay)
                report_mismatch("motor_relay", want.motor_relay, got.motor_relay);
            if (got.fan_relay !== want.fan_relay)
                report_mismatch("fan_relay", want.fan_relay, got.fan_relay);
            if (got.trip_active !== want.trip_active)
                report_mismatch("trip_active", want.trip_active, got.trip_active);
            if (got.inrush_blanking !== want.inrush_blanking)
                report_mismatch("inrush_blanking", want.inrush_blanking, got.inrush_blanking);
            if (got.alert_mask !== want.alert_mask)
                report_mismatch("alert_mask", want.alert_mask, got.alert_mask);
            if (got.stop_cause !== want.stop_cause)
                report_mismatch("stop_cause", want.stop_cause, got.stop_cause);
            if (got.cycles_done !== want.cycles_done)
                report_mismatch("cycles_done", want.cycles_done, got.cycles_done);
        end
        checked++;
    endtask
endclass

module tb_battery_relay_protection_controller_top;

    localparam int unsigned CycleLimit = 1_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [brpc_pkg::AddrWidth-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    brpc_in_if  in_if ();
    brpc_out_if res_if ();

    battery_relay_protection_controller_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    relay_tick_model sb = new();

    bit                  quiet;
    int                  stall_left;
    int                  walk_temp = 250;
    logic [31:0]         clock_ms;
    int unsigned         cycle_count;
    brpc_pkg::t_in_word  seen_word;
    brpc_pkg::t_res_word seen_res;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones; none during quiet stretches
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || stall_left > 0) begin
            res_if.ready <= 1'b0;
            if (stall_left > 0) stall_left--;
        end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 99) < 20) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                seen_word.temp_dc    = in_if.temp_dc;
                seen_word.pack_mv    = in_if.pack_mv;
                seen_word.current_ma = in_if.current_ma;
                seen_word.fault_flag = in_if.fault_flag;
                seen_word.now_ms     = in_if.now_ms;
                sb.note_tick(seen_word);
            end
            if (res_if.valid && res_if.ready) begin
                seen_res.charge_relay    = res_if.charge_relay;
                seen_res.motor_relay     = res_if.motor_relay;
                seen_res.fan_relay       = res_if.fan_relay;
                seen_res.trip_active     = res_if.trip_active;
                seen_res.inrush_blanking = res_if.inrush_blanking;
                seen_res.alert_mask      = res_if.alert_mask;
                seen_res.stop_cause      = res_if.stop_cause;
                seen_res.cycles_done     = res_if.cycles_done;
                sb.check_result(seen_res);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_tick(input brpc_pkg::t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.temp_dc    <= w.temp_dc;
        in_if.pack_mv    <= w.pack_mv;
        in_if.current_ma <= w.current_ma;
        in_if.fault_flag <= w.fault_flag;
        in_if.now_ms     <= w.now_ms;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic send_fields(input int temp, input int pack, input int cur,
                               input bit fault, input logic [31:0] stamp);
        brpc_pkg::t_in_word w;
        w.temp_dc    = 12'(temp);
        w.pack_mv    = 16'(pack);
        w.current_ma = 16'(cur);
        w.fault_flag = fault;
        w.now_ms     = stamp;
        send_tick(w);
    endtask

    // hold the sender until every outstanding result has drained
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [brpc_pkg::RegIdxWidth-1:0] idx, input int value,
                             input int width);
        logic [31:0] mask;
        logic [31:0] data;
        mask = (32'd1 << width) - 32'd1;
        // unused upper bits carry noise
        data = ($urandom() & ~mask) | (32'(value) & mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_cfg(input int trip, input int rel, input int fan, input int on_mv,
                             input int off_mv, input int inflow, input int window);
        wait_idle();
        cfg_write(brpc_pkg::REG_TRIP_TEMP, trip, 12);
        cfg_write(brpc_pkg::REG_RELEASE_TEMP, rel, 12);
        cfg_write(brpc_pkg::REG_FAN_TEMP, fan, 12);
        cfg_write(brpc_pkg::REG_CHG_BEGIN, on_mv, 16);
        cfg_write(brpc_pkg::REG_CHG_END, off_mv, 16);
        cfg_write(brpc_pkg::REG_INFLOW_LIMIT, inflow, 16);
        cfg_write(brpc_pkg::REG_BLANK_WINDOW, window, 16);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_cfg(input bit ordered);
        int a;
        int b;
        int c;
        int tmp;
        int on_mv;
        a = int'($urandom_range(0, 1650)) - 400;
        b = int'($urandom_range(0, 1650)) - 400;
        c = int'($urandom_range(0, 1650)) - 400;
        if (ordered) begin
            // release <= fan start <= trip
            if (a > b) begin tmp = a; a = b; b = tmp; end
            if (b > c) begin tmp = b; b = c; c = tmp; end
            if (a > b) begin tmp = a; a = b; b = tmp; end
            on_mv = $urandom_range(8000, 12000);
            apply_cfg(c, a, b, on_mv, on_mv + int'($urandom_range(0, 3000)),
                      -int'($urandom_range(0, 2000)), $urandom_range(0, 3000));
        end else begin
            apply_cfg(a, b, c, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      -int'($urandom_range(0, 32768)), $urandom_range(0, 65535));
        end
    endtask

    // temperature walks and voltage/current cluster around the live thresholds
    function automatic brpc_pkg::t_in_word next_random_tick();
        brpc_pkg::t_in_word w;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            walk_temp += int'($urandom_range(0, 80)) - 40;
        end else if (r < 92) begin
            case ($urandom_range(0, 2))
                0:       walk_temp = int'(sb.trip_lvl);
                1:       walk_temp = int'(sb.release_lvl);
                default: walk_temp = int'(sb.fan_lvl);
            endcase
            walk_temp += int'($urandom_range(0, 20)) - 10;
        end
        if (walk_temp > 1250) walk_temp = 1250;
        if (walk_temp < -400) walk_temp = -400;
        w.temp_dc = (r >= 92) ? 12'($urandom()) : 12'(walk_temp);

        r = $urandom_range(0, 99);
        if (r < 40)
            w.pack_mv = 16'(int'(sb.chg_on_mv) + int'($urandom_range(0, 400)) - 200);
        else if (r < 80)
            w.pack_mv = 16'(int'(sb.chg_off_mv) + int'($urandom_range(0, 400)) - 200);
        else
            w.pack_mv = 16'($urandom());

        r = $urandom_range(0, 99);
        if (r < 60)
            w.current_ma = 16'(int'(sb.inflow_lvl) + int'($urandom_range(0, 600)) - 300);
        else if (r < 85)
            w.current_ma = 16'(int'($urandom_range(0, 1200)) - 600);
        else
            w.current_ma = 16'($urandom());

        w.fault_flag = ($urandom_range(0, 99) < 6);

        r = $urandom_range(0, 99);
        if (r < 90)
            clock_ms += $urandom_range(0, 120);
        else if (r < 97)
            clock_ms += $urandom();
        else
            clock_ms = $urandom();
        w.now_ms = clock_ms;
        return w;
    endfunction

    initial begin
        i_rst_n          = 1'b0;
        quiet            = 1'b0;
        stall_left       = 0;
        cycle_count      = 0;
        clock_ms         = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_if.valid      = 1'b0;
        in_if.temp_dc    = '0;
        in_if.pack_mv    = '0;
        in_if.current_ma = '0;
        in_if.fault_flag = 1'b0;
        in_if.now_ms     = '0;
        res_if.ready     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass at reset thresholds
        send_fields(250, 12000, 0, 0, 32'd0);           // motor enabled out of reset
        send_fields(250, 11000, 0, 0, 32'd10);          // charge ready at threshold
        send_fields(250, 12600, 0, 0, 32'd20);          // charge complete
        send_fields(250, 10000, 0, 0, 32'd30);
        send_fields(600, 10000, 0, 0, 32'd40);          // trip opens charge silently
        send_fields(349, 10000, 0, 0, 32'd1000);        // clear, window opens
        send_fields(349, 11500, 0, 0, 32'd1499);
        send_fields(349, 11500, 0, 0, 32'd1500);        // window just closed
        send_fields(349, 11500, 0, 1, 32'd1600);        // fault stops charge
        send_fields(349, 11500, -201, 0, 32'd1700);     // inflow start
        send_fields(349, 11500, -200, 0, 32'hFFFF_FF00); // inflow stop, new stamp
        send_fields(349, 11500, -200, 0, 32'h0000_0010); // window across the wrap
        send_fields(349, 11500, -200, 0, 32'h0000_1000);
        send_fields(349, 11500, -200, 0, 32'hFFFF_FF00); // stale stamp comes around
        send_fields(-2048, 0, -32768, 0, 32'hFFFF_FFFF);
        send_fields(2047, 65535, 32767, 1, 32'd0);
        send_fields(399, 40000, 0, 0, 32'd5);
        send_fields(350, 40000, 0, 0, 32'd6);
        send_fields(349, 40000, 0, 0, 32'd7);           // clear and fan off together
        send_fields(400, 40000, 0, 0, 32'd8);
        send_fields(380, 40000, 0, 0, 32'd9);
        send_fields(300, 40000, 0, 0, 32'd10);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apply_cfg(600, 350, 400, 11000, 12600, -200, 500);
                1: apply_cfg(1250, -400, 1250, 0, 65535, -32768, 0);
                // release above trip and begin above end
                2: apply_cfg(-400, 1250, -400, 65535, 0, 0, 65535);
                3: apply_cfg(2047, -2048, -2048, 12000, 12000, 32767, 1);
                default: random_cfg(ph[0]);
            endcase
            for (int k = 0; k < 170; k++) begin
                quiet = (k >= 60 && k < 100);
                if ($urandom_range(0, 199) == 0) wait_idle();
                send_tick(next_random_tick());
            end
        end
        quiet = 1'b0;

        wait_idle();
        if (sb.err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
rtl/brpc_pkg.sv
rtl/brpc_if.sv
rtl/brpc_cfg.sv
rtl/brpc_core.sv
rtl/battery_relay_protection_controller_top.sv
tb/sv/tb_battery_relay_protection_controller_top.sv
